### hw/rtl/gcd_pkg.sv
// Shared constants, tables and rounding helpers for the great-circle distance core.
package gcd_pkg;

    localparam int CORDIC_STAGES_DEF = 24;

    // Coordinate differences fit 26-bit two's complement.
    localparam int DIFF_W = 26;
    // Binary angles, 2^32 units per turn.
    localparam int ANG_W = 32;
    // CORDIC datapath width with headroom for the gain and the angle sum.
    localparam int CW = 34;
    // Square-root result bits (Q30 value up to 1.0).
    localparam int ROOT_W = 31;
    // Width of one entry in the degree-to-angle remainder table.
    localparam int FRAC_W = 13;
    localparam int DIV45_N = 45;

    localparam logic [26:0] RECIP_45 = 27'd95443717;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
    localparam logic signed [CW-1:0] ONE_Q30 = CW'(1073741824);
    localparam logic [29:0] PI_Q28 = 30'd843314857;
    localparam logic [15:0] RADIUS_RESET = 16'd6371;

    localparam logic [0:0] REG_RADIUS = 1'b0;

    function automatic logic [29:0] atan_turns(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0: v = 30'd536870912;
            5'd1: v = 30'd316933406;
            5'd2: v = 30'd167458907;
            5'd3: v = 30'd85004756;
            5'd4: v = 30'd42667331;
            5'd5: v = 30'd21354465;
            5'd6: v = 30'd10679838;
            5'd7: v = 30'd5340245;
            5'd8: v = 30'd2670163;
            5'd9: v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Entry b holds round((b << shift) / 45) for b in 0..44; built at elaboration.
    function automatic logic [DIV45_N*FRAC_W-1:0] frac_table(input int shift);
        logic [DIV45_N*FRAC_W-1:0] tbl;
        int v;
        tbl = '0;
        for (int b = 0; b < DIV45_N; b++)
        begin
            v = ((b << shift) + 22) / DIV45_N;
            tbl[b*FRAC_W +: FRAC_W] = FRAC_W'(v);
        end
        return tbl;
    endfunction

    // Q30 rounding of a product, halves away from zero.
    function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        r = (mag + 64'(1 << 29)) >> 30;
        return p[63] ? -signed'(32'(r)) : signed'(32'(r));
    endfunction

endpackage

### hw/rtl/gcd_angle.sv
// Degree to binary-angle conversion with exact rounded division by 45.
module gcd_angle #(
    parameter int SHIFT = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ce,
    input  logic                                 vld_in,
    input  logic signed [gcd_pkg::DIFF_W-1:0]    deg_in,
    output logic                                 vld_out,
    output logic signed [gcd_pkg::ANG_W-1:0]     z_out,
    output logic                                 neg_out
);
    import gcd_pkg::*;

    localparam logic [DIV45_N*FRAC_W-1:0] FRAC_TBL = frac_table(SHIFT);

    logic [2:0]        vld_reg;
    logic [1:0]        sgn_reg;
    logic [DIFF_W-1:0] mag_reg;
    logic [52:0]       prod_reg;
    logic [20:0]       quo_reg;
    logic [5:0]        rem_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic              neg_reg;

    logic [DIFF_W-1:0] mag_next;
    logic [20:0]       q0;
    logic [26:0]       q0_x45;
    logic [6:0]        r0;
    logic [20:0]       quo_next;
    logic [5:0]        rem_next;
    logic [33:0]       res;
    logic signed [35:0] val;
    logic signed [ANG_W-1:0] z_next;
    logic              neg_next;

    assign mag_next = deg_in[DIFF_W-1] ? DIFF_W'(-deg_in) : DIFF_W'(deg_in);

    // The reciprocal estimate is at most one low; one compare fixes it.
    always_comb
    begin
        q0 = prod_reg[52:32];
        q0_x45 = (27'(q0) << 5) + (27'(q0) << 3) + (27'(q0) << 2) + 27'(q0);
        r0 = 7'(27'(mag_reg) - q0_x45);
        if (r0 >= 7'(DIV45_N))
        begin
            quo_next = q0 + 21'd1;
            rem_next = 6'(r0 - 7'(DIV45_N));
        end
        else
        begin
            quo_next = q0;
            rem_next = 6'(r0);
        end
    end

    always_comb
    begin
        res = (34'(quo_reg) << SHIFT) + 34'(FRAC_TBL[rem_reg*FRAC_W +: FRAC_W]);
        val = sgn_reg[1] ? -signed'({2'b00, res}) : signed'({2'b00, res});
    end

    generate
        if (SHIFT == 12)
        begin : g_half
            // Half angle reduced modulo a half turn.
            always_comb
            begin
                z_next = {val[30], val[30:0]};
                neg_next = 1'b0;
            end
        end
        else
        begin : g_full
            // Fold into [-90, 90] degrees; the cosine then changes sign.
            logic signed [32:0] t;
            always_comb
            begin
                t = {val[31], val[31:0]};
                neg_next = 1'b0;
                if (t > 33'(ONE_Q30))
                begin
                    t = t - 33'sh080000000;
                    neg_next = 1'b1;
                end
                else if (t < -33'(ONE_Q30))
                begin
                    t = t + 33'sh080000000;
                    neg_next = 1'b1;
                end
                z_next = t[31:0];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sgn_reg   <= {sgn_reg[0], deg_in[DIFF_W-1]};
            mag_reg   <= mag_next;
            prod_reg  <= 53'(mag_next) * 53'(RECIP_45);
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            z_reg     <= z_next;
            neg_reg   <= neg_next;
        end
    end

    assign vld_out = vld_reg[2];
    assign z_out   = z_reg;
    assign neg_out = neg_reg;

endmodule

### hw/rtl/gcd_cordic_rot.sv
// Rotation-mode CORDIC, one registered stage per iteration, giving cosine and sine.
module gcd_cordic_rot #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ce,
    input  logic                              vld_in,
    input  logic signed [gcd_pkg::ANG_W-1:0]  z_in,
    input  logic                              neg_in,
    output logic                              vld_out,
    output logic signed [gcd_pkg::ANG_W-1:0]  cos_out,
    output logic signed [gcd_pkg::ANG_W-1:0]  sin_out
);
    import gcd_pkg::*;

    logic signed [CW-1:0] x_reg [STAGES];
    logic signed [CW-1:0] y_reg [STAGES];
    logic signed [CW-1:0] z_reg [STAGES];
    logic [STAGES-1:0]    vld_reg;
    logic [STAGES-1:0]    neg_reg;
    logic                 vld_o_reg;
    logic signed [ANG_W-1:0] cos_reg;
    logic signed [ANG_W-1:0] sin_reg;
    logic signed [CW-1:0] xcl;
    logic signed [CW-1:0] ycl;

    generate
        for (genvar i = 0; i < STAGES; i++)
        begin : g_stage
            localparam logic signed [CW-1:0] ATAN = CW'(atan_turns(5'(i)));
            logic signed [CW-1:0] xc;
            logic signed [CW-1:0] yc;
            logic signed [CW-1:0] zc;
            logic vc;
            logic nc;
            if (i == 0)
            begin : g_first
                assign xc = CORDIC_GAIN;
                assign yc = '0;
                assign zc = CW'(z_in);
                assign vc = vld_in;
                assign nc = neg_in;
            end
            else
            begin : g_rest
                assign xc = x_reg[i-1];
                assign yc = y_reg[i-1];
                assign zc = z_reg[i-1];
                assign vc = vld_reg[i-1];
                assign nc = neg_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (ce)
                begin
                    vld_reg[i] <= vc;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    neg_reg[i] <= nc;
                    if (!zc[CW-1])
                    begin
                        x_reg[i] <= xc - (yc >>> i);
                        y_reg[i] <= yc + (xc >>> i);
                        z_reg[i] <= zc - ATAN;
                    end
                    else
                    begin
                        x_reg[i] <= xc + (yc >>> i);
                        y_reg[i] <= yc - (xc >>> i);
                        z_reg[i] <= zc + ATAN;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        xcl = x_reg[STAGES-1];
        if (xcl > ONE_Q30)
        begin
            xcl = ONE_Q30;
        end
        else if (xcl < -ONE_Q30)
        begin
            xcl = -ONE_Q30;
        end
        ycl = y_reg[STAGES-1];
        if (ycl > ONE_Q30)
        begin
            ycl = ONE_Q30;
        end
        else if (ycl < -ONE_Q30)
        begin
            ycl = -ONE_Q30;
        end
        if (neg_reg[STAGES-1])
        begin
            xcl = -xcl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_o_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cos_reg <= xcl[ANG_W-1:0];
            sin_reg <= ycl[ANG_W-1:0];
        end
    end

    assign vld_out = vld_o_reg;
    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

### hw/rtl/gcd_isqrt.sv
// Pipelined integer square root of a Q30 value, one result bit per stage.
module gcd_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          vld_in,
    input  logic [gcd_pkg::ROOT_W-1:0]    v_in,
    output logic                          vld_out,
    output logic [gcd_pkg::ROOT_W-1:0]    root_out
);
    import gcd_pkg::*;

    localparam int NW = 2 * ROOT_W;

    logic [NW-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    generate
        for (genvar s = 0; s < ROOT_W; s++)
        begin : g_stage
            localparam int J = ROOT_W - 1 - s;
            logic [NW-1:0]     remc;
            logic [ROOT_W-1:0] rc;
            logic [NW-1:0]     trial;
            logic              vc;
            if (s == 0)
            begin : g_first
                assign remc = NW'(v_in) << (ROOT_W - 1);
                assign rc   = '0;
                assign vc   = vld_in;
            end
            else
            begin : g_rest
                assign remc = rem_reg[s-1];
                assign rc   = root_reg[s-1];
                assign vc   = vld_reg[s-1];
            end

            // Remainder stays n - r*r; try setting bit J of the root.
            assign trial = (NW'(rc) << (J + 1)) + (NW'(1) << (2 * J));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (ce)
                begin
                    vld_reg[s] <= vc;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (remc >= trial)
                    begin
                        rem_reg[s]  <= remc - trial;
                        root_reg[s] <= rc | (ROOT_W'(1) << J);
                    end
                    else
                    begin
                        rem_reg[s]  <= remc;
                        root_reg[s] <= rc;
                    end
                end
            end
        end
    endgenerate

    assign vld_out  = vld_reg[ROOT_W-1];
    assign root_out = root_reg[ROOT_W-1];

endmodule

### hw/rtl/gcd_cordic_vec.sv
// Vectoring-mode CORDIC giving atan2(y, x) as a binary angle, clamped to a quarter turn.
module gcd_cordic_vec #(
    parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          vld_in,
    input  logic [gcd_pkg::ROOT_W-1:0]    y_in,
    input  logic [gcd_pkg::ROOT_W-1:0]    x_in,
    output logic                          vld_out,
    output logic [gcd_pkg::ROOT_W-1:0]    ang_out
);
    import gcd_pkg::*;

    logic signed [CW-1:0] x_reg [STAGES];
    logic signed [CW-1:0] y_reg [STAGES];
    logic signed [CW-1:0] z_reg [STAGES];
    logic [STAGES-1:0]    vld_reg;
    logic                 vld_o_reg;
    logic [ROOT_W-1:0]    ang_reg;
    logic signed [CW-1:0] zcl;

    generate
        for (genvar i = 0; i < STAGES; i++)
        begin : g_stage
            localparam logic signed [CW-1:0] ATAN = CW'(atan_turns(5'(i)));
            logic signed [CW-1:0] xc;
            logic signed [CW-1:0] yc;
            logic signed [CW-1:0] zc;
            logic vc;
            if (i == 0)
            begin : g_first
                assign xc = CW'(x_in);
                assign yc = CW'(y_in);
                assign zc = '0;
                assign vc = vld_in;
            end
            else
            begin : g_rest
                assign xc = x_reg[i-1];
                assign yc = y_reg[i-1];
                assign zc = z_reg[i-1];
                assign vc = vld_reg[i-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (ce)
                begin
                    vld_reg[i] <= vc;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    if (!yc[CW-1])
                    begin
                        x_reg[i] <= xc + (yc >>> i);
                        y_reg[i] <= yc - (xc >>> i);
                        z_reg[i] <= zc + ATAN;
                    end
                    else
                    begin
                        x_reg[i] <= xc - (yc >>> i);
                        y_reg[i] <= yc + (xc >>> i);
                        z_reg[i] <= zc - ATAN;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        zcl = z_reg[STAGES-1];
        if (zcl[CW-1])
        begin
            zcl = '0;
        end
        else if (zcl > ONE_Q30)
        begin
            zcl = ONE_Q30;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_o_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ang_reg <= zcl[ROOT_W-1:0];
        end
    end

    assign vld_out = vld_o_reg;
    assign ang_out = ang_reg;

endmodule

### hw/rtl/great_circle_distance_core.sv
// Haversine great-circle distance core: top level with products, scaling and output buffer.
// Throughput: one transaction per cycle while the spare output entry is free; every stage
// is a register, the CORDIC iterations and the 31 square-root steps each take one stage.
// A two-entry output buffer lets the pipeline keep moving while a result waits.
// Reset clears all valid bits and the buffer, and sets the radius to 6371 km.
module great_circle_distance_core #(
    parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [23:0] first_latitude, [48:24] first_longitude,
    // [72:49] second_latitude, [97:73] second_longitude, [103:98] zero
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [25:0] distance, [31:26] zero
    output logic [31:0]   m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gcd_pkg::*;

    logic        ce;
    logic [15:0] radius_reg;

    // Input stage
    logic                     vld_s0_reg;
    logic signed [DIFF_W-1:0] lat1_reg;
    logic signed [DIFF_W-1:0] lat2_reg;
    logic signed [DIFF_W-1:0] dlat_reg;
    logic signed [DIFF_W-1:0] dlon_reg;
    logic signed [DIFF_W-1:0] lat1_ext;
    logic signed [DIFF_W-1:0] lat2_ext;
    logic signed [DIFF_W-1:0] lon1_ext;
    logic signed [DIFF_W-1:0] lon2_ext;

    // Angle and CORDIC lanes
    logic                    vld_ang;
    logic signed [ANG_W-1:0] z_dlat;
    logic signed [ANG_W-1:0] z_dlon;
    logic signed [ANG_W-1:0] z_lat1;
    logic signed [ANG_W-1:0] z_lat2;
    logic                    neg_dlat;
    logic                    neg_dlon;
    logic                    neg_lat1;
    logic                    neg_lat2;
    logic                    vld_rot;
    logic signed [ANG_W-1:0] sin_dlat;
    logic signed [ANG_W-1:0] sin_dlon;
    logic signed [ANG_W-1:0] cos_lat1;
    logic signed [ANG_W-1:0] cos_lat2;

    // Product stages
    logic               vld_m1_reg;
    logic               vld_m2_reg;
    logic               vld_m3_reg;
    logic               vld_m4_reg;
    logic signed [63:0] p_sslat_reg;
    logic signed [63:0] p_sslon_reg;
    logic signed [63:0] p_cc_reg;
    logic signed [31:0] sslat_reg;
    logic signed [31:0] sslon_reg;
    logic signed [31:0] cc_reg;
    logic signed [63:0] p_t_reg;
    logic signed [31:0] sslat_d_reg;
    logic [ROOT_W-1:0]  a_reg;
    logic [ROOT_W-1:0]  b_reg;
    logic signed [32:0] a_sum;
    logic [ROOT_W-1:0]  a_next;

    // Root and arctangent
    logic              vld_sq;
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;
    logic              vld_vec;
    logic [ROOT_W-1:0] ang;

    // Scaling stages
    logic        vld_q1_reg;
    logic        vld_q2_reg;
    logic        vld_q3_reg;
    logic [60:0] pz_reg;
    logic [45:0] q_reg;
    logic [38:0] ph_reg;
    logic [38:0] pl_reg;
    logic [61:0] pz_sum;
    logic [62:0] d_sum;
    logic [25:0] d_next;

    // Output buffer
    logic        push;
    logic        pop;
    logic        out_vld_reg;
    logic [25:0] out_reg;
    logic        sp_vld_reg;
    logic [25:0] sp_reg;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? {16'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIUS))
        begin
            radius_reg <= pwdata[15:0];
        end
    end

    // The whole pipeline moves unless the spare output entry is occupied.
    assign ce = !sp_vld_reg;
    assign s_axis_tready = ce;

    assign lat1_ext = DIFF_W'(signed'(s_axis_tdata[23:0]));
    assign lon1_ext = DIFF_W'(signed'(s_axis_tdata[48:24]));
    assign lat2_ext = DIFF_W'(signed'(s_axis_tdata[72:49]));
    assign lon2_ext = DIFF_W'(signed'(s_axis_tdata[97:73]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s0_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_s0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lat1_reg <= lat1_ext;
            lat2_reg <= lat2_ext;
            dlat_reg <= lat2_ext - lat1_ext;
            dlon_reg <= lon2_ext - lon1_ext;
        end
    end

    gcd_angle #(.SHIFT(12)) u_ang_dlat (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_s0_reg), .deg_in(dlat_reg),
        .vld_out(vld_ang), .z_out(z_dlat), .neg_out(neg_dlat)
    );
    gcd_angle #(.SHIFT(12)) u_ang_dlon (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_s0_reg), .deg_in(dlon_reg),
        .vld_out(), .z_out(z_dlon), .neg_out(neg_dlon)
    );
    gcd_angle #(.SHIFT(13)) u_ang_lat1 (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_s0_reg), .deg_in(lat1_reg),
        .vld_out(), .z_out(z_lat1), .neg_out(neg_lat1)
    );
    gcd_angle #(.SHIFT(13)) u_ang_lat2 (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_s0_reg), .deg_in(lat2_reg),
        .vld_out(), .z_out(z_lat2), .neg_out(neg_lat2)
    );

    gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_ang), .z_in(z_dlat),
        .neg_in(neg_dlat), .vld_out(vld_rot), .cos_out(), .sin_out(sin_dlat)
    );
    gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_ang), .z_in(z_dlon),
        .neg_in(neg_dlon), .vld_out(), .cos_out(), .sin_out(sin_dlon)
    );
    gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_ang), .z_in(z_lat1),
        .neg_in(neg_lat1), .vld_out(), .cos_out(cos_lat1), .sin_out()
    );
    gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_ang), .z_in(z_lat2),
        .neg_in(neg_lat2), .vld_out(), .cos_out(cos_lat2), .sin_out()
    );

    always_comb
    begin
        a_sum = 33'(sslat_d_reg) + 33'(rnd_q30(p_t_reg));
        if (a_sum[32])
        begin
            a_next = '0;
        end
        else if (a_sum > 33'(ONE_Q30))
        begin
            a_next = ROOT_W'(ONE_Q30);
        end
        else
        begin
            a_next = a_sum[ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m1_reg <= 1'b0;
            vld_m2_reg <= 1'b0;
            vld_m3_reg <= 1'b0;
            vld_m4_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_m1_reg <= vld_rot;
            vld_m2_reg <= vld_m1_reg;
            vld_m3_reg <= vld_m2_reg;
            vld_m4_reg <= vld_m3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_sslat_reg <= 64'(sin_dlat) * 64'(sin_dlat);
            p_sslon_reg <= 64'(sin_dlon) * 64'(sin_dlon);
            p_cc_reg    <= 64'(cos_lat1) * 64'(cos_lat2);
            sslat_reg   <= rnd_q30(p_sslat_reg);
            sslon_reg   <= rnd_q30(p_sslon_reg);
            cc_reg      <= rnd_q30(p_cc_reg);
            p_t_reg     <= 64'(cc_reg) * 64'(sslon_reg);
            sslat_d_reg <= sslat_reg;
            a_reg       <= a_next;
            b_reg       <= ROOT_W'(ONE_Q30) - a_next;
        end
    end

    gcd_isqrt u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_m4_reg), .v_in(a_reg),
        .vld_out(vld_sq), .root_out(root_a)
    );
    gcd_isqrt u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_m4_reg), .v_in(b_reg),
        .vld_out(), .root_out(root_b)
    );

    gcd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_atan (
        .clk(clk), .rst_n(rst_n), .ce(ce), .vld_in(vld_sq), .y_in(root_a),
        .x_in(root_b), .vld_out(vld_vec), .ang_out(ang)
    );

    // Angle times pi gives the central angle; then scale by the radius into 1/256 km.
    assign pz_sum = 62'(pz_reg) + 62'(1 << 13);
    assign d_sum  = (63'(ph_reg) << 23) + 63'(pl_reg) + (63'(1) << 35);
    assign d_next = d_sum[61:36];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_q1_reg <= 1'b0;
            vld_q2_reg <= 1'b0;
            vld_q3_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_q1_reg <= vld_vec;
            vld_q2_reg <= vld_q1_reg;
            vld_q3_reg <= vld_q2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pz_reg <= 61'(ang) * 61'(PI_Q28);
            q_reg  <= pz_sum[59:14];
            ph_reg <= 39'(radius_reg) * 39'(q_reg[45:23]);
            pl_reg <= 39'(radius_reg) * 39'(q_reg[22:0]);
        end
    end

    // Output buffer: main entry plus one spare that absorbs the in-flight result.
    assign push = ce && vld_q3_reg;
    assign pop  = out_vld_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sp_vld_reg  <= 1'b0;
        end
        else if (sp_vld_reg)
        begin
            if (pop)
            begin
                sp_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                sp_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_vld_reg)
        begin
            if (pop)
            begin
                out_reg <= sp_reg;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                sp_reg <= d_next;
            end
            else
            begin
                out_reg <= d_next;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_reg};

endmodule
